FILE: hdl/fpw_pkg.sv
`default_nettype none

package fpw_pkg;

   // Field widths of the request and response words.
   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned PA_W     = 52;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned INDEX_W  = 9;
   localparam int unsigned LEVEL_W  = 2;

   // Opcodes.
   localparam logic OPCODE_STORE     = 1'b0;
   localparam logic OPCODE_TRANSLATE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_TRANSLATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAULT      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STORED     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

   // Page table entry fields.
   localparam logic [WORD_W-1:0] FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
   localparam int unsigned       PRESENT_BIT = 0;
   localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 2'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_PD   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_PT   = 2'd0;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE_FIND,
      ST_WALK_ADDR,
      ST_WALK_FIND,
      ST_WALK_FINAL,
      ST_FINISH
   } state_type;

   // Commands from the sequencer to the lookup table.
   typedef struct packed {
      logic              search;
      logic              write_hit;
      logic              append;
      logic [ADDR_W-1:0] key;
      logic [WORD_W-1:0] word;
   } lookup_cmd_type;

   // Status returned by the lookup table; hit and word hold until the next search, full follows the fill count.
   typedef struct packed {
      logic              done;
      logic              hit;
      logic              full;
      logic [WORD_W-1:0] word;
   } lookup_res_type;

endpackage

`default_nettype wire

FILE: hdl/fpw_req_if.sv
`default_nettype none

interface fpw_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [fpw_pkg::ADDR_W-1:0]  address;
   logic [fpw_pkg::WORD_W-1:0]  word_value;

   modport source (output valid, output opcode, output address, output word_value,
                   input ready);
   modport sink (input valid, input opcode, input address, input word_value,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/fpw_rsp_if.sv
`default_nettype none

interface fpw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fpw_pkg::STATUS_W-1:0]  status;
   logic [fpw_pkg::PA_W-1:0]      physical_address;

   modport source (output valid, output status, output physical_address, input ready);
   modport sink (input valid, input status, input physical_address, output ready);
endinterface

`default_nettype wire

FILE: hdl/four_level_page_walker.sv
`default_nettype none

// Four-level page walker over a sparse word memory of up to TABLE_ENTRIES
// address/word pairs. A store word writes or overwrites one memory word; a
// new address with the table full is dropped and reported. A translate word
// walks the PML4, PDPT, PD and PT entries from csr_wr_data's root base and
// returns the physical address or a page fault. Each memory lookup scans the
// filled slots through the table's registered read port, one slot per cycle,
// and stops at the first match. A translation stops at the first level that
// faults. One word is worked on at a time; the response register lets the
// next request be taken while a response waits.
module four_level_page_walker #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [fpw_pkg::WORD_W-1:0]  csr_wr_data,
   fpw_req_if.sink                          req_bus,
   fpw_rsp_if.source                        rsp_bus
);

   fpw_pkg::state_type state_ff, state_in;

   logic [fpw_pkg::WORD_W-1:0]   root_base_ff;
   logic                         op_ff, op_in;
   logic [fpw_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [fpw_pkg::WORD_W-1:0]   value_ff, value_in;
   logic [fpw_pkg::WORD_W-1:0]   base_ff, base_in;
   logic [fpw_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [fpw_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [fpw_pkg::PA_W-1:0]     pend_pa_ff, pend_pa_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fpw_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [fpw_pkg::PA_W-1:0]     rsp_pa_ff, rsp_pa_in;

   fpw_pkg::lookup_cmd_type      lk_cmd;
   fpw_pkg::lookup_res_type      lk_res;

   logic                         accept;
   logic                         out_free;
   logic [fpw_pkg::INDEX_W-1:0]  level_index;
   logic [fpw_pkg::ADDR_W-1:0]   add_b;
   logic [fpw_pkg::ADDR_W-1:0]   add_sum;
   logic                         entry_ok;
   logic [fpw_pkg::STATUS_W-1:0] store_status;

   fpw_lookup #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_lookup (
      .clock (clock),
      .reset (reset),
      .cmd   (lk_cmd),
      .res   (lk_res)
   );

   // Handshake helpers and the shared address adder.
   always_comb begin
      accept   = req_bus.valid && req_bus.ready;
      out_free = !rsp_valid_ff || rsp_bus.ready;
      entry_ok = lk_res.hit && lk_res.word[fpw_pkg::PRESENT_BIT];
      store_status = (lk_res.hit || !lk_res.full) ? fpw_pkg::STATUS_STORED
                                                  : fpw_pkg::STATUS_FULL;
      unique case (level_ff)
         fpw_pkg::LEVEL_PML4: level_index = addr_ff[47:39];
         fpw_pkg::LEVEL_PDPT: level_index = addr_ff[38:30];
         fpw_pkg::LEVEL_PD:   level_index = addr_ff[29:21];
         fpw_pkg::LEVEL_PT:   level_index = addr_ff[20:12];
         default:             level_index = addr_ff[20:12];
      endcase
      if (state_ff == fpw_pkg::ST_WALK_FINAL) begin
         add_b = {{(fpw_pkg::ADDR_W - fpw_pkg::OFFSET_W){1'b0}},
                  addr_ff[fpw_pkg::OFFSET_W-1:0]};
      end else begin
         add_b = {{(fpw_pkg::ADDR_W - fpw_pkg::INDEX_W - 3){1'b0}}, level_index, 3'b000};
      end
      add_sum = base_ff + add_b;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_bus.opcode == fpw_pkg::OPCODE_STORE) ? fpw_pkg::ST_STORE_FIND
                                                                   : fpw_pkg::ST_WALK_ADDR;
            end
         end
         fpw_pkg::ST_STORE_FIND: begin
            if (lk_res.done) begin
               state_in = fpw_pkg::ST_FINISH;
            end
         end
         fpw_pkg::ST_WALK_ADDR: state_in = fpw_pkg::ST_WALK_FIND;
         fpw_pkg::ST_WALK_FIND: begin
            if (lk_res.done) begin
               if (!entry_ok) begin
                  state_in = fpw_pkg::ST_FINISH;
               end else if (level_ff == fpw_pkg::LEVEL_PT) begin
                  state_in = fpw_pkg::ST_WALK_FINAL;
               end else begin
                  state_in = fpw_pkg::ST_WALK_ADDR;
               end
            end
         end
         fpw_pkg::ST_WALK_FINAL: state_in = fpw_pkg::ST_FINISH;
         fpw_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = fpw_pkg::ST_IDLE;
            end
         end
         default: state_in = fpw_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: request ready and lookup commands.
   always_comb begin
      req_bus.ready    = (state_ff == fpw_pkg::ST_IDLE);
      lk_cmd.search    = 1'b0;
      lk_cmd.write_hit = 1'b0;
      lk_cmd.append    = 1'b0;
      lk_cmd.key       = addr_ff;
      lk_cmd.word      = value_ff;
      unique case (state_ff)
         fpw_pkg::ST_IDLE: begin
            lk_cmd.search = accept && (req_bus.opcode == fpw_pkg::OPCODE_STORE);
            lk_cmd.key    = req_bus.address;
         end
         fpw_pkg::ST_WALK_ADDR: begin
            lk_cmd.search = 1'b1;
            lk_cmd.key    = add_sum;
         end
         fpw_pkg::ST_FINISH: begin
            if (out_free && (op_ff == fpw_pkg::OPCODE_STORE)) begin
               lk_cmd.write_hit = lk_res.hit;
               lk_cmd.append    = !lk_res.hit && !lk_res.full;
            end
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      op_in          = op_ff;
      addr_in        = addr_ff;
      value_in       = value_ff;
      base_in        = base_ff;
      level_in       = level_ff;
      pend_status_in = pend_status_ff;
      pend_pa_in     = pend_pa_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_pa_in      = rsp_pa_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         fpw_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_bus.opcode;
               addr_in  = req_bus.address;
               value_in = req_bus.word_value;
               base_in  = root_base_ff;
               level_in = fpw_pkg::LEVEL_PML4;
            end
         end
         fpw_pkg::ST_WALK_FIND: begin
            if (lk_res.done) begin
               if (!entry_ok) begin
                  pend_status_in = fpw_pkg::STATUS_FAULT;
                  pend_pa_in     = '0;
               end else begin
                  base_in  = lk_res.word & fpw_pkg::FRAME_MASK;
                  level_in = level_ff - fpw_pkg::LEVEL_W'(1);
               end
            end
         end
         fpw_pkg::ST_WALK_FINAL: begin
            pend_status_in = fpw_pkg::STATUS_TRANSLATED;
            pend_pa_in     = add_sum[fpw_pkg::PA_W-1:0];
         end
         fpw_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == fpw_pkg::OPCODE_STORE) begin
                  rsp_status_in = store_status;
                  rsp_pa_in     = '0;
               end else begin
                  rsp_status_in = pend_status_ff;
                  rsp_pa_in     = pend_pa_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         root_base_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            root_base_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      value_ff       <= value_in;
      base_ff        <= base_in;
      level_ff       <= level_in;
      pend_status_ff <= pend_status_in;
      pend_pa_ff     <= pend_pa_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pa_ff      <= rsp_pa_in;
   end

   // Response port.
   always_comb begin
      rsp_bus.valid            = rsp_valid_ff;
      rsp_bus.status           = rsp_status_ff;
      rsp_bus.physical_address = rsp_pa_ff;
   end

`ifndef SYNTHESIS
   // A lookup completes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      lk_res.done |-> (state_ff == fpw_pkg::ST_STORE_FIND ||
                       state_ff == fpw_pkg::ST_WALK_FIND))
      else $error("lookup completed outside a wait state");

   // Only a successful translation carries a physical address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != fpw_pkg::STATUS_TRANSLATED) |-> (rsp_pa_ff == '0))
      else $error("nonzero physical address on a non-translated response");

   // A store response never reports a fault or a translation.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpw_pkg::ST_FINISH && out_free && op_ff == fpw_pkg::OPCODE_STORE)
      |=> (rsp_status_ff == fpw_pkg::STATUS_STORED || rsp_status_ff == fpw_pkg::STATUS_FULL))
      else $error("store produced a translate status");

   // After a request is taken the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("request accepted while the previous one is in flight");
`endif

endmodule

`default_nettype wire

FILE: hdl/fpw_lookup.sv
`default_nettype none

// Associative word table. Slots fill in order, so a slot is valid exactly when
// its index is below the fill count. A search scans the valid slots one per
// cycle through the registered read port and stops at the first match.
module fpw_lookup #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fpw_pkg::lookup_cmd_type cmd,
   output fpw_pkg::lookup_res_type      res
);

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

   logic [fpw_pkg::ADDR_W-1:0] entry_address_ff [TABLE_ENTRIES];
   logic [fpw_pkg::WORD_W-1:0] entry_word_ff [TABLE_ENTRIES];

   logic [CNT_W-1:0]           used_ff, used_in;
   logic                       scanning_ff, scanning_in;
   logic [CNT_W-1:0]           scan_ptr_ff, scan_ptr_in;
   logic [fpw_pkg::ADDR_W-1:0] key_ff, key_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic [fpw_pkg::ADDR_W-1:0] rd_addr_ff;
   logic [fpw_pkg::WORD_W-1:0] rd_word_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic                       done_ff, done_in;
   logic                       hit_ff, hit_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic [fpw_pkg::WORD_W-1:0] hit_word_ff, hit_word_in;

   logic                       full;
   logic                       match;
   logic                       issue;
   logic                       finish;
   logic                       append_ok;
   logic                       word_wr_en;
   logic [IDX_W-1:0]           word_wr_idx;

   // Scan control: compare the word read last cycle while reading the next slot.
   always_comb begin
      full        = (used_ff == ENTRIES_CNT);
      match       = rd_valid_ff && (rd_addr_ff == key_ff);
      issue       = scanning_ff && (scan_ptr_ff < used_ff) && !match;
      finish      = scanning_ff && (match || (!issue && !rd_valid_ff));
      append_ok   = cmd.append && !full;
      word_wr_en  = cmd.write_hit || append_ok;
      word_wr_idx = cmd.write_hit ? hit_idx_ff : used_ff[IDX_W-1:0];
   end

   // Next values of the control and result registers.
   always_comb begin
      scanning_in = scanning_ff;
      scan_ptr_in = scan_ptr_ff;
      key_in      = key_ff;
      used_in     = used_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_word_in = hit_word_ff;
      rd_valid_in = issue;
      done_in     = finish;
      if (cmd.search) begin
         scanning_in = 1'b1;
         scan_ptr_in = '0;
         key_in      = cmd.key;
      end else begin
         if (finish) begin
            scanning_in = 1'b0;
         end
         if (issue) begin
            scan_ptr_in = scan_ptr_ff + CNT_W'(1);
         end
      end
      if (finish) begin
         hit_in      = match;
         hit_idx_in  = rd_idx_ff;
         hit_word_in = rd_word_ff;
      end
      if (append_ok) begin
         used_in = used_ff + CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         scanning_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         used_ff     <= used_in;
         scanning_ff <= scanning_in;
         rd_valid_ff <= rd_valid_in;
         done_ff     <= done_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_word_ff <= hit_word_in;
   end

   // Table memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_addr_ff <= entry_address_ff[scan_ptr_ff[IDX_W-1:0]];
         rd_word_ff <= entry_word_ff[scan_ptr_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_ptr_ff[IDX_W-1:0];
      end
      if (append_ok) begin
         entry_address_ff[used_ff[IDX_W-1:0]] <= cmd.key;
      end
      if (word_wr_en) begin
         entry_word_ff[word_wr_idx] <= cmd.word;
      end
   end

   // A miss reads as zero.
   always_comb begin
      res.done = done_ff;
      res.hit  = hit_ff;
      res.full = full;
      res.word = hit_ff ? hit_word_ff : '0;
   end

endmodule

`default_nettype wire

FILE: verif/four_level_page_walker_test.sv
`default_nettype none

module four_level_page_walker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS    = 64;
   // Once a root has a mapping, new ones are only built while four more slots fit in this many.
   localparam int MAPPING_BUDGET = 52;
   // Random stores to fresh addresses stop here until the table-full test.
   localparam int NOISE_BUDGET   = 56;
   // Long enough that two full walks on a full table finish inside it.
   localparam int LONG_HOLD_OFF  = 1200;
   localparam int SETTLE_CYCLES  = 300;
   localparam int MAX_REPORTS    = 10;

   // Bits that the walk must mask away: 63:52 and the flags in 11:1.
   localparam logic [fpw_pkg::WORD_W-1:0] SPARE_BITS = 64'hFFF0_0000_0000_0FFE;
   localparam logic [fpw_pkg::ADDR_W-1:0] ALL_ONES   = '1;

   typedef struct packed {
      logic [fpw_pkg::STATUS_W-1:0] status;
      logic [fpw_pkg::PA_W-1:0]     pa;
   } walk_outcome_type;

   // One linear-to-physical mapping as laid out in memory; index 3 is PML4.
   typedef struct packed {
      logic [fpw_pkg::ADDR_W-1:0]          root;
      logic [3:0][fpw_pkg::INDEX_W-1:0]    idx;
      logic [3:0][fpw_pkg::ADDR_W-1:0]     entry_addr;
      logic [3:0][fpw_pkg::WORD_W-1:0]     entry_word;
   } page_mapping_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [fpw_pkg::WORD_W-1:0]   csr_wr_data = '0;

   fpw_req_if req_bus ();
   fpw_rsp_if rsp_bus ();

   // Mirror of the sparse memory and of the root base register.
   logic [fpw_pkg::ADDR_W-1:0]   mirror_addr [TABLE_SLOTS];
   logic [fpw_pkg::WORD_W-1:0]   mirror_word [TABLE_SLOTS];
   int                           mirror_used = 0;
   logic [fpw_pkg::ADDR_W-1:0]   root_base_model = '0;

   walk_outcome_type             awaited_outcomes [$];
   page_mapping_type             mappings [$];
   logic [fpw_pkg::ADDR_W-1:0]   main_root;
   logic [fpw_pkg::ADDR_W-1:0]   second_root;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_off_active = 1'b0;
   event long_hold_off;

   int words_sent = 0;
   int stores_sent = 0;
   int stores_dropped = 0;
   int translations_sent = 0;
   int walks_faulted = 0;
   int roots_written = 0;
   int responses_seen = 0;
   int mismatch_count = 0;

   four_level_page_walker #(
      .TABLE_ENTRIES(TABLE_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [fpw_pkg::ADDR_W-1:0] linear_address(
         logic [15:0] upper, logic [3:0][fpw_pkg::INDEX_W-1:0] idx,
         logic [fpw_pkg::OFFSET_W-1:0] offset);
      return {upper, idx, offset};
   endfunction

   function automatic int find_mirror_slot(logic [fpw_pkg::ADDR_W-1:0] addr);
      for (int i = 0; i < mirror_used; i++) begin
         if (mirror_addr[i] == addr) begin
            return i;
         end
      end
      return -1;
   endfunction

   // An address that was never stored reads as zero.
   function automatic logic [fpw_pkg::WORD_W-1:0] read_mirror(
         logic [fpw_pkg::ADDR_W-1:0] addr);
      int slot;
      slot = find_mirror_slot(addr);
      return (slot < 0) ? '0 : mirror_word[slot];
   endfunction

   // Applies one word to the mirror and returns the response it must produce.
   function automatic walk_outcome_type translate_or_store(
         logic op, logic [fpw_pkg::ADDR_W-1:0] addr, logic [fpw_pkg::WORD_W-1:0] val);
      walk_outcome_type            result;
      logic [fpw_pkg::ADDR_W-1:0]  base;
      logic [fpw_pkg::WORD_W-1:0]  entry;
      logic [fpw_pkg::INDEX_W-1:0] idx;
      int                          slot;
      int                          lvl;
      bit                          faulted;
      result.status = fpw_pkg::STATUS_STORED;
      result.pa = '0;
      if (op == fpw_pkg::OPCODE_STORE) begin
         slot = find_mirror_slot(addr);
         if (slot >= 0) begin
            mirror_word[slot] = val;
         end else if (mirror_used < TABLE_SLOTS) begin
            mirror_addr[mirror_used] = addr;
            mirror_word[mirror_used] = val;
            mirror_used++;
         end else begin
            result.status = fpw_pkg::STATUS_FULL;
         end
      end else begin
         // Walk PML4 down to PT; the entry address wraps modulo 2^64.
         base = root_base_model;
         faulted = 1'b0;
         for (lvl = 3; lvl >= 0 && !faulted; lvl--) begin
            idx = addr[fpw_pkg::OFFSET_W + fpw_pkg::INDEX_W * lvl +: fpw_pkg::INDEX_W];
            entry = read_mirror(base + {idx, 3'b000});
            if (!entry[fpw_pkg::PRESENT_BIT]) begin
               faulted = 1'b1;
            end else begin
               base = entry & fpw_pkg::FRAME_MASK;
            end
         end
         if (faulted) begin
            result.status = fpw_pkg::STATUS_FAULT;
         end else begin
            result.status = fpw_pkg::STATUS_TRANSLATED;
            result.pa = base[fpw_pkg::PA_W-1:0] + addr[fpw_pkg::OFFSET_W-1:0];
         end
      end
      return result;
   endfunction

   function automatic int pick_mapping(logic [fpw_pkg::ADDR_W-1:0] root);
      int hits [$];
      foreach (mappings[i]) begin
         if (mappings[i].root == root) begin
            hits.push_back(i);
         end
      end
      if (hits.size() == 0) begin
         return -1;
      end
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
   endtask

   // Compares one accepted response with the oldest awaited outcome.
   task automatic check_outcome(input logic [fpw_pkg::STATUS_W-1:0] got_status,
                                input logic [fpw_pkg::PA_W-1:0] got_pa);
      walk_outcome_type want;
      responses_seen++;
      if (awaited_outcomes.size() == 0) begin
         note_failure($sformatf("response %0d with nothing awaited: status %0d address %h",
                                responses_seen, got_status, got_pa));
      end else begin
         want = awaited_outcomes.pop_front();
         if (got_status !== want.status) begin
            note_failure($sformatf("response %0d status: expected %0d, got %0d",
                                   responses_seen, want.status, got_status));
         end
         if (got_pa !== want.pa) begin
            note_failure($sformatf("response %0d address: expected %h, got %h",
                                   responses_seen, want.pa, got_pa));
         end
      end
   endtask

   // Response side: sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_outcome(rsp_bus.status, rsp_bus.physical_address);
      end
   end

   // Receiver readiness, changed at the falling edge.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_active) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // A long receiver hold-off, counted here in clock cycles.
   always begin
      @(long_hold_off);
      hold_off_active = 1'b1;
      repeat (LONG_HOLD_OFF) @(posedge clock);
      hold_off_active = 1'b0;
   end

   // Offers one word and records its outcome once the block accepts it.
   task automatic offer_word(input logic op, input logic [fpw_pkg::ADDR_W-1:0] addr,
                             input logic [fpw_pkg::WORD_W-1:0] val);
      walk_outcome_type outcome;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.address <= addr;
      req_bus.word_value <= val;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      outcome = translate_or_store(op, addr, val);
      awaited_outcomes.push_back(outcome);
      words_sent++;
      if (op == fpw_pkg::OPCODE_STORE) begin
         stores_sent++;
         if (outcome.status == fpw_pkg::STATUS_FULL) begin
            stores_dropped++;
         end
      end else begin
         translations_sent++;
         if (outcome.status == fpw_pkg::STATUS_FAULT) begin
            walks_faulted++;
         end
      end
   endtask

   // Stops offering and waits for every awaited response; returns at a rising edge.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_root(input logic [fpw_pkg::WORD_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      root_base_model = value;
      roots_written++;
   endtask

   // Stores the four entries of a new mapping; sometimes it shares the upper
   // tables of an existing one under the same root and stores only the rest.
   task automatic build_mapping(input logic [fpw_pkg::ADDR_W-1:0] root, input bit may_share,
                                input bit spare_bits_set);
      page_mapping_type           m;
      logic [fpw_pkg::ADDR_W-1:0] table_base;
      int                         pick;
      int                         kept;
      int                         lvl;
      kept = 0;
      m = '0;
      pick = pick_mapping(root);
      if (may_share && pick >= 0 && $urandom_range(1) == 1) begin
         m = mappings[pick];
         kept = $urandom_range(3, 1);
      end
      m.root = root;
      for (lvl = 3; lvl >= 0; lvl--) begin
         if (3 - lvl >= kept) begin
            table_base = (lvl == 3) ? root
                                    : (m.entry_word[lvl + 1] & fpw_pkg::FRAME_MASK);
            m.idx[lvl] = fpw_pkg::INDEX_W'($urandom);
            m.entry_addr[lvl] = table_base + {m.idx[lvl], 3'b000};
            m.entry_word[lvl] = rand64();
            if (spare_bits_set) begin
               m.entry_word[lvl] = m.entry_word[lvl] | SPARE_BITS;
            end
            m.entry_word[lvl][fpw_pkg::PRESENT_BIT] = 1'b1;
            offer_word(fpw_pkg::OPCODE_STORE, m.entry_addr[lvl], m.entry_word[lvl]);
         end
      end
      mappings.push_back(m);
   endtask

   task automatic translate_mapping(input page_mapping_type m);
      offer_word(fpw_pkg::OPCODE_TRANSLATE,
                 linear_address(16'($urandom), m.idx, fpw_pkg::OFFSET_W'($urandom)),
                 rand64());
   endtask

   // Rewrites one entry of a mapping: not present, garbage, or restored.
   task automatic disturb_entry(input page_mapping_type m);
      logic [fpw_pkg::WORD_W-1:0] value;
      int                         lvl;
      lvl = $urandom_range(3);
      case ($urandom_range(2))
         0: begin
            value = {m.entry_word[lvl][fpw_pkg::WORD_W-1:1], 1'b0};
         end
         1: begin
            value = rand64();
         end
         default: begin
            value = m.entry_word[lvl];
         end
      endcase
      offer_word(fpw_pkg::OPCODE_STORE, m.entry_addr[lvl], value);
   endtask

   task automatic well_formed_sequence(input logic [fpw_pkg::ADDR_W-1:0] root);
      int pick;
      pick = pick_mapping(root);
      if (pick < 0 || (mirror_used + 4 <= MAPPING_BUDGET && $urandom_range(3) == 0)) begin
         build_mapping(root, 1'b1, 1'b0);
         pick = mappings.size() - 1;
      end else if ($urandom_range(2) == 0) begin
         disturb_entry(mappings[pick]);
      end
      repeat ($urandom_range(3, 1)) begin
         translate_mapping(mappings[pick]);
      end
   endtask

   task automatic noise_word(input logic [fpw_pkg::ADDR_W-1:0] root);
      logic [3:0][fpw_pkg::INDEX_W-1:0] idx;
      logic [fpw_pkg::ADDR_W-1:0]       addr;
      int                               pick;
      pick = pick_mapping(root);
      case ($urandom_range(2))
         0: begin
            offer_word(fpw_pkg::OPCODE_TRANSLATE, rand64(), rand64());
         end
         1: begin
            // A known mapping with one index replaced at random, so the walk may stray at that level.
            if (pick >= 0) begin
               idx = mappings[pick].idx;
               idx[$urandom_range(3)] = fpw_pkg::INDEX_W'($urandom);
               offer_word(fpw_pkg::OPCODE_TRANSLATE,
                          linear_address(16'($urandom), idx, fpw_pkg::OFFSET_W'($urandom)),
                          rand64());
            end else begin
               offer_word(fpw_pkg::OPCODE_TRANSLATE, rand64(), rand64());
            end
         end
         default: begin
            if (mirror_used < NOISE_BUDGET || mirror_used >= TABLE_SLOTS
                || mappings.size() == 0) begin
               addr = rand64();
            end else begin
               addr = mappings[$urandom_range(mappings.size() - 1)].entry_addr[$urandom_range(3)];
            end
            offer_word(fpw_pkg::OPCODE_STORE, addr, rand64());
         end
      endcase
   endtask

   task automatic run_traffic_phase(input int send_pct, input int stall_pct,
                                    input logic [fpw_pkg::ADDR_W-1:0] root,
                                    input int word_count);
      int start;
      wait_drained();
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      write_root(root);
      start = words_sent;
      while (words_sent - start < word_count) begin
         if ($urandom_range(99) < 70) begin
            well_formed_sequence(root);
         end else begin
            noise_word(root);
         end
      end
   endtask

   // Empty memory: every lookup reads zero, so the first level faults.
   task automatic test_empty_memory();
      write_root('0);
      offer_word(fpw_pkg::OPCODE_TRANSLATE, '0, '0);
      offer_word(fpw_pkg::OPCODE_TRANSLATE, ALL_ONES, ALL_ONES);
   endtask

   // One complete mapping, walked twice, with every ignored entry bit set and the PS bit on.
   task automatic test_single_walk();
      wait_drained();
      main_root = rand64();
      second_root = rand64();
      write_root(main_root);
      build_mapping(main_root, 1'b0, 1'b1);
      offer_word(fpw_pkg::OPCODE_TRANSLATE,
                 linear_address(16'h0000, mappings[0].idx, '0), '0);
      offer_word(fpw_pkg::OPCODE_TRANSLATE,
                 linear_address(16'hFFFF, mappings[0].idx, '1), ALL_ONES);
   endtask

   // Clear the present bit at each level in turn, then restore it by overwriting.
   task automatic test_level_faults();
      page_mapping_type m;
      int               lvl;
      m = mappings[0];
      for (lvl = 3; lvl >= 0; lvl--) begin
         offer_word(fpw_pkg::OPCODE_STORE, m.entry_addr[lvl],
                    {m.entry_word[lvl][fpw_pkg::WORD_W-1:1], 1'b0});
         translate_mapping(m);
         offer_word(fpw_pkg::OPCODE_STORE, m.entry_addr[lvl], m.entry_word[lvl]);
      end
   endtask

   // Root base at all ones wraps index 1 to address 7; root zero with index 0
   // reads address 0.
   task automatic test_root_extremes();
      page_mapping_type                 m;
      logic [3:0][fpw_pkg::INDEX_W-1:0] moved_idx;
      m = mappings[0];
      moved_idx = m.idx;
      wait_drained();
      write_root(ALL_ONES);
      offer_word(fpw_pkg::OPCODE_STORE, 64'd7, m.entry_word[3]);
      moved_idx[3] = 9'd1;
      offer_word(fpw_pkg::OPCODE_TRANSLATE,
                 linear_address(16'($urandom), moved_idx, 12'hABC), '0);
      wait_drained();
      write_root('0);
      offer_word(fpw_pkg::OPCODE_STORE, '0, m.entry_word[3]);
      moved_idx[3] = '0;
      offer_word(fpw_pkg::OPCODE_TRANSLATE,
                 linear_address(16'($urandom), moved_idx, 12'h123), '0);
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(0, 0, main_root, 400);
      run_traffic_phase(69, 0, second_root, 400);
      run_traffic_phase(0, 69, main_root, 400);
      run_traffic_phase(28, 28, second_root, 350);
   endtask

   // Fill every slot, then fresh addresses are dropped while held ones still update.
   task automatic test_table_full();
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_root(main_root);
      while (mirror_used < TABLE_SLOTS) begin
         offer_word(fpw_pkg::OPCODE_STORE, rand64(), rand64());
      end
      repeat (4) begin
         offer_word(fpw_pkg::OPCODE_STORE, rand64(), rand64());
      end
      offer_word(fpw_pkg::OPCODE_STORE, mappings[0].entry_addr[0],
                 {mappings[0].entry_word[0][fpw_pkg::WORD_W-1:1], 1'b0});
      translate_mapping(mappings[0]);
      offer_word(fpw_pkg::OPCODE_STORE, mappings[0].entry_addr[0],
                 mappings[0].entry_word[0]);
      translate_mapping(mappings[0]);
   endtask

   // The receiver holds off while words keep coming, so the input stalls;
   // then the sender pauses until everything is back.
   task automatic test_response_backpressure();
      int pick;
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_root(main_root);
      @(posedge clock);
      -> long_hold_off;
      repeat (12) begin
         pick = pick_mapping(main_root);
         translate_mapping(mappings[pick]);
      end
      wait_drained();
      repeat (5) begin
         pick = pick_mapping(main_root);
         translate_mapping(mappings[pick]);
      end
   endtask

   task automatic test_traffic_on_full_table();
      run_traffic_phase(28, 28, main_root, 250);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = fpw_pkg::OPCODE_STORE;
      req_bus.address = '0;
      req_bus.word_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_memory();
      test_single_walk();
      test_level_faults();
      test_root_extremes();
      test_random_traffic();
      test_table_full();
      test_response_backpressure();
      test_traffic_on_full_table();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_outcomes.size() != 0) begin
         note_failure($sformatf("%0d responses never arrived", awaited_outcomes.size()));
      end

      $display("Covered %0d words: %0d stores, %0d dropped, %0d walks, %0d faulted.",
               words_sent, stores_sent, stores_dropped, translations_sent, walks_faulted);
      $display("%0d root writes, idling up to 69 in 100, a %0d-cycle hold-off; %0d bad.",
               roots_written, LONG_HOLD_OFF, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung block.
   initial begin
      #50_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
